### rtl/core/frcf_pkg.sv
// shared constants and types of the rectangle and circle fill engine
package frcf_pkg;

  localparam int FB_WORDS = 65536;
  localparam int MAX_DIM  = 4096;

  localparam int ADDR_W  = $clog2(FB_WORDS);
  localparam int DIM_W   = 13;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int PIX_W   = 32;
  localparam int ARG_W   = 16;
  localparam int CALC_W  = ARG_W + 2;
  localparam int SQ_W    = 32;

  // command modes
  localparam logic [1:0] MODE_PLOT   = 2'd0;
  localparam logic [1:0] MODE_RECT   = 2'd1;
  localparam logic [1:0] MODE_CIRCLE = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

  typedef struct packed {
    logic [PIX_W-1:0]        color;
    logic signed [ARG_W-1:0] radius;
    logic signed [ARG_W-1:0] rect_height;
    logic signed [ARG_W-1:0] rect_width;
    logic signed [ARG_W-1:0] pos_y;
    logic signed [ARG_W-1:0] pos_x;
  } cmd_t;

endpackage

### rtl/core/framebuffer_rect_circle_fill.sv
// rectangle and filled circle rasterizer over an internal 32-bit framebuffer
//
//  channel  | dir | accepted when          | content
//  ---------+-----+------------------------+------------------------------------------
//  in_      | in  | in_tvalid & in_tready  | tuser: mode; tdata: x, y, w, h, r, color
//  out_     | out | out_tvalid & out_tready| tuser: status; tdata: pixel_value
//  cfg_     | in  | cfg_we                 | cfg_index selects register, cfg_wdata
//
// sequence: plot, rect and circle pass setup, prep, one fill step per pixel of the clipped
//   box (the single write port of the frame store visits one pixel a cycle) and done; a
//   read passes setup, prep, rd and done; a command that does nothing goes from setup to done
// reset: synchronous active-low rst_n clears the sequencer and output valid and sets
//   all canvas registers to 256; frame store contents are undefined until written
// stalls: a finished result waits in the output register while the next command
//   is taken; the sequencer only holds in its final state if that register is full
module framebuffer_rect_circle_fill (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [111:0]                in_tdata,   // pos_x, pos_y, rect_width,
                                                  // rect_height, radius, color
  input  logic [1:0]                  in_tuser,   // mode
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // pixel_value
  output logic                        out_tuser,  // status
  // configuration writes
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [frcf_pkg::DIM_W-1:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int AW = frcf_pkg::ADDR_W;
  localparam int CW = frcf_pkg::COORD_W;
  localparam int DW = frcf_pkg::DIM_W;
  localparam int KW = frcf_pkg::CALC_W;
  localparam int SW = frcf_pkg::SQ_W;

  // canvas registers
  logic [DW-1:0] canvas_width_r;
  logic [DW-1:0] canvas_height_r;
  logic [DW-1:0] row_stride_r;

  // sequencer and command
  logic [2:0]            state_r;
  logic [1:0]            mode_r;
  frcf_pkg::cmd_t        cmd_r;

  // clipped box, inclusive bounds
  logic [CW-1:0]         left_r;
  logic [CW-1:0]         right_r;
  logic [CW-1:0]         top_r;
  logic [CW-1:0]         bottom_r;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         row_r;
  logic [AW-1:0]         row_base_r;

  // incremental distance terms for the circle
  logic signed [KW-1:0]  dx_r;
  logic signed [KW-1:0]  dx0_r;
  logic signed [KW-1:0]  dy_r;
  logic [SW-1:0]         dx2_r;
  logic [SW-1:0]         dx0sq_r;
  logic [SW-1:0]         dy2_r;
  logic [SW-1:0]         rr_r;
  logic                  hit_r;

  // result
  logic [31:0]           res_value_r;
  logic                  res_status_r;
  logic                  out_valid_r;
  logic [31:0]           out_value_r;
  logic                  out_status_r;

  // frame store
  logic [frcf_pkg::PIX_W-1:0] frame_mem [frcf_pkg::FB_WORDS];
  logic [frcf_pkg::PIX_W-1:0] rd_q_r;
  logic [AW-1:0]              mem_addr;
  logic                       mem_we;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // ---------------------------------------------------------------------------
  // setup: canvas check and clipping of the command's box
  // ---------------------------------------------------------------------------
  logic [2*DW-1:0]      area;
  logic                 canvas_ok;
  logic signed [KW-1:0] px, py, pw, ph, pr;
  logic signed [KW-1:0] lx, ex, ly, ey;
  logic signed [KW-1:0] cw_s, ch_s;
  logic signed [KW-1:0] left_s, rex_s, top_s, bey_s;
  logic signed [KW-1:0] right_s, bottom_s;
  logic                 args_ok;
  logic                 box_ok;

  always_comb begin
    area = DW'(row_stride_r) * DW'(canvas_height_r);
    canvas_ok = (canvas_width_r != '0) && (canvas_height_r != '0) &&
                (row_stride_r >= canvas_width_r) &&
                (canvas_width_r <= DW'(frcf_pkg::MAX_DIM)) &&
                (canvas_height_r <= DW'(frcf_pkg::MAX_DIM)) &&
                (row_stride_r <= DW'(frcf_pkg::MAX_DIM)) &&
                ({1'b0, area} <= (2*DW+1)'(frcf_pkg::FB_WORDS));

    px = KW'(cmd_r.pos_x);
    py = KW'(cmd_r.pos_y);
    pw = KW'(cmd_r.rect_width);
    ph = KW'(cmd_r.rect_height);
    pr = KW'(cmd_r.radius);
    cw_s = KW'(signed'({1'b0, canvas_width_r}));
    ch_s = KW'(signed'({1'b0, canvas_height_r}));

    // half-open box [lx, ex) x [ly, ey) before clipping
    case (mode_r)
      frcf_pkg::MODE_RECT: begin
        lx = px;  ex = px + pw;
        ly = py;  ey = py + ph;
        args_ok = (pw > 0) && (ph > 0);
      end
      frcf_pkg::MODE_CIRCLE: begin
        lx = px - pr;  ex = px + pr + KW'(1);
        ly = py - pr;  ey = py + pr + KW'(1);
        args_ok = (pr >= 0);
      end
      default: begin
        lx = px;  ex = px + KW'(1);
        ly = py;  ey = py + KW'(1);
        args_ok = 1'b1;
      end
    endcase

    left_s   = (lx < 0) ? '0 : lx;
    top_s    = (ly < 0) ? '0 : ly;
    rex_s    = (ex > cw_s) ? cw_s : ex;
    bey_s    = (ey > ch_s) ? ch_s : ey;
    right_s  = rex_s - KW'(1);
    bottom_s = bey_s - KW'(1);
    box_ok   = canvas_ok && args_ok && (left_s < rex_s) && (top_s < bey_s);
  end

  // ---------------------------------------------------------------------------
  // prep: first row address and distance squares
  // ---------------------------------------------------------------------------
  logic [CW+DW-1:0]       base_prod;
  logic signed [KW-1:0]   dx0_c, dy0_c;
  logic signed [2*KW-1:0] dx0_sq, dy0_sq;
  logic signed [2*KW-1:0] r_sq;

  always_comb begin
    base_prod = CW'(top_r) * DW'(row_stride_r);
    dx0_c  = KW'(signed'({1'b0, left_r})) - px;
    dy0_c  = KW'(signed'({1'b0, top_r})) - py;
    dx0_sq = dx0_c * dx0_c;
    dy0_sq = dy0_c * dy0_c;
    r_sq   = pr * pr;
  end

  // ---------------------------------------------------------------------------
  // fill: one pixel a cycle
  // ---------------------------------------------------------------------------
  logic             in_circle;
  logic             col_last;
  logic             row_last;
  logic [SW+1:0]    dx2_step;
  logic [SW+1:0]    dy2_step;

  always_comb begin
    in_circle = (mode_r != frcf_pkg::MODE_CIRCLE) ||
                (({1'b0, dx2_r} + {1'b0, dy2_r}) <= {1'b0, rr_r});
    col_last = (col_r == right_r);
    row_last = (row_r == bottom_r);
    // (d+1)^2 = d^2 + 2d + 1, with d negative left of and above the center
    dx2_step = (SW+2)'({2'b00, dx2_r}) + (SW+2)'(signed'({dx_r, 1'b0})) + (SW+2)'(1);
    dy2_step = (SW+2)'({2'b00, dy2_r}) + (SW+2)'(signed'({dy_r, 1'b0})) + (SW+2)'(1);
    mem_addr = row_base_r + AW'(col_r);
    mem_we   = (state_r == ST_FILL) && in_circle &&
               (mode_r != frcf_pkg::MODE_READ);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= cmd_r.color;
    end
    rd_q_r <= frame_mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= frcf_pkg::DIM_RESET;
      canvas_height_r <= frcf_pkg::DIM_RESET;
      row_stride_r    <= frcf_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        frcf_pkg::REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata;
        frcf_pkg::REG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata;
        frcf_pkg::REG_ROW_STRIDE:    row_stride_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // command payload and box registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mode_r <= in_tuser;
        cmd_r  <= frcf_pkg::cmd_t'(in_tdata);
      end
      ST_SETUP: begin
        left_r   <= left_s[CW-1:0];
        right_r  <= right_s[CW-1:0];
        top_r    <= top_s[CW-1:0];
        bottom_r <= bottom_s[CW-1:0];
      end
      ST_PREP: begin
        col_r      <= left_r;
        row_r      <= top_r;
        row_base_r <= base_prod[AW-1:0];
        dx0_r      <= dx0_c;
        dx_r       <= dx0_c;
        dy_r       <= dy0_c;
        dx0sq_r    <= dx0_sq[SW-1:0];
        dx2_r      <= dx0_sq[SW-1:0];
        dy2_r      <= dy0_sq[SW-1:0];
        rr_r       <= r_sq[SW-1:0];
      end
      ST_FILL: begin
        if (col_last) begin
          col_r      <= left_r;
          row_r      <= row_r + CW'(1);
          row_base_r <= row_base_r + AW'(row_stride_r);
          dx_r       <= dx0_r;
          dx2_r      <= dx0sq_r;
          dy_r       <= dy_r + KW'(1);
          dy2_r      <= dy2_step[SW-1:0];
        end else begin
          col_r <= col_r + CW'(1);
          dx_r  <= dx_r + KW'(1);
          dx2_r <= dx2_step[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      // in the final state the result register is reloaded below instead
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          res_value_r  <= '0;
          res_status_r <= 1'b1;
          hit_r        <= 1'b0;
          state_r      <= box_ok ? ST_PREP : ST_DONE;
        end
        ST_PREP: begin
          state_r <= (mode_r == frcf_pkg::MODE_READ) ? ST_RD : ST_FILL;
        end
        ST_FILL: begin
          if (in_circle) begin
            hit_r <= 1'b1;
          end
          if (col_last && row_last) begin
            // circle: acted only if some pixel fell inside the radius
            if (mode_r == frcf_pkg::MODE_CIRCLE) begin
              res_status_r <= !(hit_r || in_circle);
            end else begin
              res_status_r <= 1'b0;
            end
            state_r <= ST_DONE;
          end
        end
        ST_RD: begin
          // frame store read data lands in rd_q_r at this edge
          res_status_r <= 1'b0;
          state_r      <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= (mode_r == frcf_pkg::MODE_READ && !res_status_r) ?
                            rd_q_r : res_value_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
